/* src/dssa_pkg.sv */
// Shared types and constants for the daily sensor statistics accumulator.
// No dependencies; used by daily_sensor_stats_accumulator.
`default_nettype none

package dssa_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TEMP_WIDTH_DEF = 8;
    localparam int LOAD_WIDTH = 7;
    localparam int DAY_WIDTH = 16;
    localparam int NUM_RESULTS = 7;

    localparam logic [LOAD_WIDTH-1:0] IDLE_LIMIT_RESET = 7'd15;

    typedef logic [15:0] count_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef enum logic [2:0] {
        OP_CPU_TEMP,
        OP_GPU_TEMP,
        OP_CPU_LOAD,
        OP_GPU_LOAD,
        OP_RAM,
        OP_CPU_IDLE,
        OP_GPU_IDLE
    } div_op_t;

    function automatic div_op_t next_op(input div_op_t op);
        div_op_t result;
        case (op)
            OP_CPU_TEMP: result = OP_GPU_TEMP;
            OP_GPU_TEMP: result = OP_CPU_LOAD;
            OP_CPU_LOAD: result = OP_GPU_LOAD;
            OP_GPU_LOAD: result = OP_RAM;
            OP_RAM:      result = OP_CPU_IDLE;
            OP_CPU_IDLE: result = OP_GPU_IDLE;
            default:     result = OP_CPU_TEMP;
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

/* src/daily_sensor_stats_accumulator.sv */
// Top level of the daily sensor statistics accumulator with its shared divider.
// Depends on dssa_pkg for types, operation codes and constants.
// A sample of the open day is registered, then accumulated, before the next one can be taken.
// A day close runs seven divisions on one restoring divider, then loads the summary into the
// output register and accumulates the closing sample into the new day before the next sample
// is taken; an unaccepted previous summary delays both the load and the next sample.
// Reset closes any open day, empties the output register and sets the idle limit to 15.
`default_nettype none

module daily_sensor_stats_accumulator #(
    parameter int COUNT_WIDTH = dssa_pkg::COUNT_WIDTH_DEF,
    parameter int TEMP_WIDTH = dssa_pkg::TEMP_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dssa_pkg::LOAD_WIDTH-1:0]       cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dssa_pkg::DAY_WIDTH-1:0]        day_number,
    input  logic signed [TEMP_WIDTH-1:0]          cpu_temp,
    input  logic signed [TEMP_WIDTH-1:0]          gpu_temp,
    input  logic [dssa_pkg::LOAD_WIDTH-1:0]       cpu_load,
    input  logic [dssa_pkg::LOAD_WIDTH-1:0]       gpu_load,
    input  logic [dssa_pkg::LOAD_WIDTH-1:0]       ram_use,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [dssa_pkg::DAY_WIDTH-1:0]        closed_day,
    output logic [15:0]                           minutes,
    output logic signed [TEMP_WIDTH-1:0]          cpu_temp_avg,
    output logic signed [TEMP_WIDTH-1:0]          cpu_temp_peak,
    output logic signed [TEMP_WIDTH-1:0]          gpu_temp_avg,
    output logic signed [TEMP_WIDTH-1:0]          gpu_temp_peak,
    output logic [dssa_pkg::LOAD_WIDTH-1:0]       cpu_load_avg,
    output logic [dssa_pkg::LOAD_WIDTH-1:0]       gpu_load_avg,
    output logic [dssa_pkg::LOAD_WIDTH-1:0]       ram_avg,
    output logic [15:0]                           idle_minutes,
    output logic signed [TEMP_WIDTH-1:0]          cpu_idle_temp_avg,
    output logic signed [TEMP_WIDTH-1:0]          gpu_idle_temp_avg
);

    localparam int LW = dssa_pkg::LOAD_WIDTH;
    localparam int DW = dssa_pkg::DAY_WIDTH;
    localparam int SUMW = COUNT_WIDTH + TEMP_WIDTH + 1;
    localparam int MAGW = COUNT_WIDTH + TEMP_WIDTH;
    localparam int LSUMW = COUNT_WIDTH + LW;
    localparam int STEPW = $clog2(TEMP_WIDTH + 2);
    localparam logic [STEPW-1:0] STEP_LAST = STEPW'(TEMP_WIDTH + 1);

    dssa_pkg::state_t  state_reg, state_next;
    dssa_pkg::div_op_t op_reg, op_next;
    logic [STEPW-1:0]  step_reg, step_next;
    logic              close_reg, close_next;
    logic              day_open_reg, day_open_next;
    logic              out_valid_reg, out_valid_next;
    logic [LW-1:0]     limit_reg, limit_next;

    logic [DW-1:0]              s_day_reg;
    logic signed [TEMP_WIDTH-1:0] s_ct_reg, s_gt_reg;
    logic [LW-1:0]              s_cl_reg, s_gl_reg, s_ram_reg;

    logic [DW-1:0]                open_day_reg;
    logic [COUNT_WIDTH-1:0]       minute_count_reg, idle_count_reg;
    logic signed [SUMW-1:0]       cpu_sum_reg, gpu_sum_reg, cpu_idle_sum_reg, gpu_idle_sum_reg;
    logic [LSUMW-1:0]             cpu_load_sum_reg, gpu_load_sum_reg, ram_sum_reg;
    logic signed [TEMP_WIDTH-1:0] cpu_peak_reg, gpu_peak_reg;

    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [TEMP_WIDTH-1:0]  quo_reg;
    logic                   neg_reg;
    logic [TEMP_WIDTH-1:0]  res_reg [dssa_pkg::NUM_RESULTS];

    logic [DW-1:0]                o_day_reg;
    logic [15:0]                  o_minutes_reg, o_idle_reg;
    logic signed [TEMP_WIDTH-1:0] o_cpu_avg_reg, o_cpu_peak_reg, o_gpu_avg_reg, o_gpu_peak_reg;
    logic signed [TEMP_WIDTH-1:0] o_cpu_idle_reg, o_gpu_idle_reg;
    logic [LW-1:0]                o_cpu_load_reg, o_gpu_load_reg, o_ram_reg;

    logic                   accept;
    logic                   out_load;
    logic                   new_day;
    logic signed [SUMW-1:0] sel_sum;
    logic signed [SUMW-1:0] abs_sum;
    logic                   sel_neg;
    logic [MAGW-1:0]        mag;
    logic [COUNT_WIDTH-1:0] divisor;
    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   ge;
    logic [TEMP_WIDTH-1:0]  q_res;
    logic                   no_idle;

    logic                         fresh;
    logic                         sat;
    logic                         idle_hit;
    logic [COUNT_WIDTH-1:0]       b_cnt, b_idle;
    logic signed [SUMW-1:0]       b_cpu, b_gpu, b_cpu_idle, b_gpu_idle;
    logic [LSUMW-1:0]             b_cl, b_gl, b_ram;
    logic signed [TEMP_WIDTH-1:0] b_cpu_peak, b_gpu_peak;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dssa_pkg::ST_IDLE;
            op_reg        <= dssa_pkg::OP_CPU_TEMP;
            step_reg      <= '0;
            close_reg     <= 1'b0;
            day_open_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= dssa_pkg::IDLE_LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            close_reg     <= close_next;
            day_open_reg  <= day_open_next;
            out_valid_reg <= out_valid_next;
            limit_reg     <= limit_next;
        end
    end

    assign new_day = day_open_reg && (day_number != open_day_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        close_next = close_reg;
        case (state_reg)
            dssa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    close_next = new_day;
                    step_next  = '0;
                    op_next    = dssa_pkg::OP_CPU_TEMP;
                    state_next = new_day ? dssa_pkg::ST_DIVIDE : dssa_pkg::ST_ACCUM;
                end
            end
            dssa_pkg::ST_DIVIDE:
            begin
                if (step_reg == STEP_LAST)
                begin
                    step_next = '0;
                    op_next   = dssa_pkg::next_op(op_reg);
                    if (op_reg == dssa_pkg::OP_GPU_IDLE)
                    begin
                        state_next = dssa_pkg::ST_EMIT;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            dssa_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = dssa_pkg::ST_ACCUM;
                end
            end
            dssa_pkg::ST_ACCUM:
            begin
                state_next = dssa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dssa_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake and control outputs.
    always_comb
    begin
        in_ready       = (state_reg == dssa_pkg::ST_IDLE);
        accept         = in_ready && in_valid;
        out_load       = (state_reg == dssa_pkg::ST_EMIT) && (!out_valid_reg || out_ready);
        out_valid_next = out_load || (out_valid_reg && !out_ready);
        day_open_next  = day_open_reg || (state_reg == dssa_pkg::ST_ACCUM);
        limit_next     = cfg_wr_en ? cfg_wr_data : limit_reg;
    end

    // Operand selection and one restoring step of the shared divider.
    always_comb
    begin
        case (op_reg)
            dssa_pkg::OP_CPU_TEMP: sel_sum = cpu_sum_reg;
            dssa_pkg::OP_GPU_TEMP: sel_sum = gpu_sum_reg;
            dssa_pkg::OP_CPU_LOAD: sel_sum = $signed(SUMW'(cpu_load_sum_reg));
            dssa_pkg::OP_GPU_LOAD: sel_sum = $signed(SUMW'(gpu_load_sum_reg));
            dssa_pkg::OP_RAM:      sel_sum = $signed(SUMW'(ram_sum_reg));
            dssa_pkg::OP_CPU_IDLE: sel_sum = cpu_idle_sum_reg;
            dssa_pkg::OP_GPU_IDLE: sel_sum = gpu_idle_sum_reg;
            default:               sel_sum = '0;
        endcase
        sel_neg = sel_sum[SUMW-1];
        abs_sum = sel_neg ? -sel_sum : sel_sum;
        mag     = abs_sum[MAGW-1:0];
        if ((op_reg == dssa_pkg::OP_CPU_IDLE) || (op_reg == dssa_pkg::OP_GPU_IDLE))
        begin
            divisor = idle_count_reg;
        end
        else
        begin
            divisor = minute_count_reg;
        end
        trial = {rem_reg, quo_reg[TEMP_WIDTH-1]};
        diff  = trial - {1'b0, divisor};
        ge    = (trial >= {1'b0, divisor});
        q_res = neg_reg ? -quo_reg : quo_reg;
    end

    // Base values for the accumulation step; a fresh day starts from zero.
    always_comb
    begin
        fresh      = close_reg || !day_open_reg;
        b_cnt      = fresh ? '0 : minute_count_reg;
        b_idle     = fresh ? '0 : idle_count_reg;
        b_cpu      = fresh ? '0 : cpu_sum_reg;
        b_gpu      = fresh ? '0 : gpu_sum_reg;
        b_cpu_idle = fresh ? '0 : cpu_idle_sum_reg;
        b_gpu_idle = fresh ? '0 : gpu_idle_sum_reg;
        b_cl       = fresh ? '0 : cpu_load_sum_reg;
        b_gl       = fresh ? '0 : gpu_load_sum_reg;
        b_ram      = fresh ? '0 : ram_sum_reg;
        b_cpu_peak = fresh ? '0 : cpu_peak_reg;
        b_gpu_peak = fresh ? '0 : gpu_peak_reg;
        sat        = (b_cnt == '1);
        idle_hit   = (s_cl_reg < limit_reg) && (s_gl_reg < limit_reg);
        no_idle    = (idle_count_reg == '0);
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_day_reg <= day_number;
            s_ct_reg  <= cpu_temp;
            s_gt_reg  <= gpu_temp;
            s_cl_reg  <= cpu_load;
            s_gl_reg  <= gpu_load;
            s_ram_reg <= ram_use;
        end

        if (state_reg == dssa_pkg::ST_DIVIDE)
        begin
            if (step_reg == '0)
            begin
                rem_reg <= mag[MAGW-1:TEMP_WIDTH];
                quo_reg <= mag[TEMP_WIDTH-1:0];
                neg_reg <= sel_neg;
            end
            else if (step_reg == STEP_LAST)
            begin
                res_reg[op_reg] <= q_res;
            end
            else
            begin
                rem_reg <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
                quo_reg <= {quo_reg[TEMP_WIDTH-2:0], ge};
            end
        end

        if (out_load)
        begin
            o_day_reg      <= open_day_reg;
            o_minutes_reg  <= dssa_pkg::count_out_t'(minute_count_reg);
            o_cpu_avg_reg  <= res_reg[dssa_pkg::OP_CPU_TEMP];
            o_gpu_avg_reg  <= res_reg[dssa_pkg::OP_GPU_TEMP];
            o_cpu_peak_reg <= cpu_peak_reg;
            o_gpu_peak_reg <= gpu_peak_reg;
            o_cpu_load_reg <= res_reg[dssa_pkg::OP_CPU_LOAD][LW-1:0];
            o_gpu_load_reg <= res_reg[dssa_pkg::OP_GPU_LOAD][LW-1:0];
            o_ram_reg      <= res_reg[dssa_pkg::OP_RAM][LW-1:0];
            o_idle_reg     <= dssa_pkg::count_out_t'(idle_count_reg);
            o_cpu_idle_reg <= no_idle ? '1 : res_reg[dssa_pkg::OP_CPU_IDLE];
            o_gpu_idle_reg <= no_idle ? '1 : res_reg[dssa_pkg::OP_GPU_IDLE];
        end

        if (state_reg == dssa_pkg::ST_ACCUM)
        begin
            if (fresh)
            begin
                open_day_reg <= s_day_reg;
            end
            if (!sat)
            begin
                minute_count_reg <= b_cnt + 1'b1;
                cpu_sum_reg      <= b_cpu + SUMW'(s_ct_reg);
                gpu_sum_reg      <= b_gpu + SUMW'(s_gt_reg);
                cpu_load_sum_reg <= b_cl + LSUMW'(s_cl_reg);
                gpu_load_sum_reg <= b_gl + LSUMW'(s_gl_reg);
                ram_sum_reg      <= b_ram + LSUMW'(s_ram_reg);
                cpu_peak_reg     <= (s_ct_reg > b_cpu_peak) ? s_ct_reg : b_cpu_peak;
                gpu_peak_reg     <= (s_gt_reg > b_gpu_peak) ? s_gt_reg : b_gpu_peak;
                if (idle_hit)
                begin
                    idle_count_reg   <= b_idle + 1'b1;
                    cpu_idle_sum_reg <= b_cpu_idle + SUMW'(s_ct_reg);
                    gpu_idle_sum_reg <= b_gpu_idle + SUMW'(s_gt_reg);
                end
                else
                begin
                    idle_count_reg   <= b_idle;
                    cpu_idle_sum_reg <= b_cpu_idle;
                    gpu_idle_sum_reg <= b_gpu_idle;
                end
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign closed_day        = o_day_reg;
    assign minutes           = o_minutes_reg;
    assign cpu_temp_avg      = o_cpu_avg_reg;
    assign cpu_temp_peak     = o_cpu_peak_reg;
    assign gpu_temp_avg      = o_gpu_avg_reg;
    assign gpu_temp_peak     = o_gpu_peak_reg;
    assign cpu_load_avg      = o_cpu_load_reg;
    assign gpu_load_avg      = o_gpu_load_reg;
    assign ram_avg           = o_ram_reg;
    assign idle_minutes      = o_idle_reg;
    assign cpu_idle_temp_avg = o_cpu_idle_reg;
    assign gpu_idle_temp_avg = o_gpu_idle_reg;

    // A new summary transaction is only ever loaded from the emit step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == dssa_pkg::ST_EMIT))
    else $error("summary transaction raised outside the emit step");

    // An open day holds at least one minute and never more idle minutes than minutes.
    assert property (@(posedge clk) disable iff (!rst_n)
        day_open_reg |-> (minute_count_reg != '0) && (idle_count_reg <= minute_count_reg))
    else $error("open day counters are inconsistent");

    // The divider remainder stays below a nonzero divisor while iterating.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dssa_pkg::ST_DIVIDE) && (step_reg != '0) && (divisor != '0)
        |-> (rem_reg < divisor))
    else $error("divider remainder out of range");

endmodule

`default_nettype wire

/* tb/daily_sensor_stats_accumulator_tb.sv */
// Self-checking testbench for daily_sensor_stats_accumulator: directed and random
// sample streams, predicted per day and compared field by field. Depends on dssa_pkg and the RTL.
`default_nettype none

module daily_sensor_stats_accumulator_tb;

    import dssa_pkg::*;

    localparam int TW = TEMP_WIDTH_DEF;
    localparam longint MINUTE_CAP = (64'd1 << COUNT_WIDTH_DEF) - 1;
    localparam int SETTLE_CYCLES = 7 * (TW + 2) + 10;
    localparam int SUMMARY_FIELDS = 12;

    typedef enum int {
        SF_CLOSED_DAY,
        SF_MINUTES,
        SF_CPU_TEMP_AVG,
        SF_CPU_TEMP_PEAK,
        SF_GPU_TEMP_AVG,
        SF_GPU_TEMP_PEAK,
        SF_CPU_LOAD_AVG,
        SF_GPU_LOAD_AVG,
        SF_RAM_AVG,
        SF_IDLE_MINUTES,
        SF_CPU_IDLE_AVG,
        SF_GPU_IDLE_AVG
    } summary_field_e;

    typedef struct {
        logic [DAY_WIDTH-1:0]  day;
        logic signed [TW-1:0]  cpu_t;
        logic signed [TW-1:0]  gpu_t;
        logic [LOAD_WIDTH-1:0] cpu_l;
        logic [LOAD_WIDTH-1:0] gpu_l;
        logic [LOAD_WIDTH-1:0] ram;
    } sample_t;

    typedef logic [SUMMARY_FIELDS-1:0][15:0] summary_t;

    string field_names [SUMMARY_FIELDS] = '{
        "closed_day", "minutes", "cpu_temp_avg", "cpu_temp_peak", "gpu_temp_avg",
        "gpu_temp_peak", "cpu_load_avg", "gpu_load_avg", "ram_avg", "idle_minutes",
        "cpu_idle_temp_avg", "gpu_idle_temp_avg"
    };

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [LOAD_WIDTH-1:0]  cfg_wr_data = IDLE_LIMIT_RESET;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [DAY_WIDTH-1:0]   day_number = '0;
    logic signed [TW-1:0]   cpu_temp = '0;
    logic signed [TW-1:0]   gpu_temp = '0;
    logic [LOAD_WIDTH-1:0]  cpu_load = '0;
    logic [LOAD_WIDTH-1:0]  gpu_load = '0;
    logic [LOAD_WIDTH-1:0]  ram_use = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b1;
    logic [DAY_WIDTH-1:0]   closed_day;
    logic [15:0]            minutes;
    logic signed [TW-1:0]   cpu_temp_avg;
    logic signed [TW-1:0]   cpu_temp_peak;
    logic signed [TW-1:0]   gpu_temp_avg;
    logic signed [TW-1:0]   gpu_temp_peak;
    logic [LOAD_WIDTH-1:0]  cpu_load_avg;
    logic [LOAD_WIDTH-1:0]  gpu_load_avg;
    logic [LOAD_WIDTH-1:0]  ram_avg;
    logic [15:0]            idle_minutes;
    logic signed [TW-1:0]   cpu_idle_temp_avg;
    logic signed [TW-1:0]   gpu_idle_temp_avg;

    sample_t  pending_samples [$];
    summary_t day_summaries [$];
    int       error_count = 0;
    int       feed_gap = 0;
    int       drain_stall = 0;
    bit       steady_flow = 1'b0;

    logic [LOAD_WIDTH-1:0] idle_limit = IDLE_LIMIT_RESET;
    bit                    day_is_open = 1'b0;
    logic [DAY_WIDTH-1:0]  cur_day = '0;
    longint minute_tally = 0;
    longint idle_tally = 0;
    longint cpu_temp_sum = 0;
    longint gpu_temp_sum = 0;
    longint cpu_load_sum = 0;
    longint gpu_load_sum = 0;
    longint ram_sum = 0;
    longint cpu_idle_sum = 0;
    longint gpu_idle_sum = 0;
    longint cpu_peak = 0;
    longint gpu_peak = 0;

    daily_sensor_stats_accumulator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .day_number        (day_number),
        .cpu_temp          (cpu_temp),
        .gpu_temp          (gpu_temp),
        .cpu_load          (cpu_load),
        .gpu_load          (gpu_load),
        .ram_use           (ram_use),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .closed_day        (closed_day),
        .minutes           (minutes),
        .cpu_temp_avg      (cpu_temp_avg),
        .cpu_temp_peak     (cpu_temp_peak),
        .gpu_temp_avg      (gpu_temp_avg),
        .gpu_temp_peak     (gpu_temp_peak),
        .cpu_load_avg      (cpu_load_avg),
        .gpu_load_avg      (gpu_load_avg),
        .ram_avg           (ram_avg),
        .idle_minutes      (idle_minutes),
        .cpu_idle_temp_avg (cpu_idle_temp_avg),
        .gpu_idle_temp_avg (gpu_idle_temp_avg)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [15:0] temp_field(input longint v);
        logic [15:0] r;
        r = '0;
        r[TW-1:0] = v[TW-1:0];
        return r;
    endfunction

    function automatic logic [15:0] load_field(input longint v);
        logic [15:0] r;
        r = '0;
        r[LOAD_WIDTH-1:0] = v[LOAD_WIDTH-1:0];
        return r;
    endfunction

    function automatic summary_t summarize_day();
        summary_t s;
        longint   n;
        n = (minute_tally < 1) ? 1 : minute_tally;
        s = '0;
        s[SF_CLOSED_DAY]    = cur_day;
        s[SF_MINUTES]       = minute_tally[15:0];
        s[SF_CPU_TEMP_AVG]  = temp_field(cpu_temp_sum / n);
        s[SF_CPU_TEMP_PEAK] = temp_field(cpu_peak);
        s[SF_GPU_TEMP_AVG]  = temp_field(gpu_temp_sum / n);
        s[SF_GPU_TEMP_PEAK] = temp_field(gpu_peak);
        s[SF_CPU_LOAD_AVG]  = load_field(cpu_load_sum / n);
        s[SF_GPU_LOAD_AVG]  = load_field(gpu_load_sum / n);
        s[SF_RAM_AVG]       = load_field(ram_sum / n);
        s[SF_IDLE_MINUTES]  = idle_tally[15:0];
        s[SF_CPU_IDLE_AVG]  = temp_field((idle_tally == 0) ? -1 : cpu_idle_sum / idle_tally);
        s[SF_GPU_IDLE_AVG]  = temp_field((idle_tally == 0) ? -1 : gpu_idle_sum / idle_tally);
        return s;
    endfunction

    task automatic account_sample(input sample_t s);
        longint ct;
        longint gt;
        ct = s.cpu_t;
        gt = s.gpu_t;
        if (day_is_open && s.day != cur_day)
        begin
            day_summaries.push_back(summarize_day());
            day_is_open = 1'b0;
            minute_tally = 0;
            idle_tally = 0;
            cpu_temp_sum = 0;
            gpu_temp_sum = 0;
            cpu_load_sum = 0;
            gpu_load_sum = 0;
            ram_sum = 0;
            cpu_idle_sum = 0;
            gpu_idle_sum = 0;
            cpu_peak = 0;
            gpu_peak = 0;
        end
        if (!day_is_open)
        begin
            day_is_open = 1'b1;
            cur_day = s.day;
        end
        if (minute_tally >= MINUTE_CAP)
            return;
        minute_tally++;
        cpu_temp_sum += ct;
        gpu_temp_sum += gt;
        cpu_load_sum += s.cpu_l;
        gpu_load_sum += s.gpu_l;
        ram_sum += s.ram;
        if (ct > cpu_peak)
            cpu_peak = ct;
        if (gt > gpu_peak)
            gpu_peak = gt;
        if (s.cpu_l < idle_limit && s.gpu_l < idle_limit)
        begin
            idle_tally++;
            cpu_idle_sum += ct;
            gpu_idle_sum += gt;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic void note_failure(input string msg);
        if (error_count < 10)
            $display("%s", msg);
        error_count++;
    endfunction

    always @(posedge clk)
    begin : sample_feed
        sample_t s;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                s.day = day_number;
                s.cpu_t = cpu_temp;
                s.gpu_t = gpu_temp;
                s.cpu_l = cpu_load;
                s.gpu_l = gpu_load;
                s.ram = ram_use;
                account_sample(s);
                feed_gap = pick_gap();
            end
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (feed_gap > 0)
            begin
                feed_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s = pending_samples.pop_front();
                in_valid <= 1'b1;
                day_number <= s.day;
                cpu_temp <= s.cpu_t;
                gpu_temp <= s.gpu_t;
                cpu_load <= s.cpu_l;
                gpu_load <= s.gpu_l;
                ram_use <= s.ram;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : summary_check
        summary_t got;
        summary_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got[SF_CLOSED_DAY]    = closed_day;
                got[SF_MINUTES]       = minutes;
                got[SF_CPU_TEMP_AVG]  = {8'h00, cpu_temp_avg};
                got[SF_CPU_TEMP_PEAK] = {8'h00, cpu_temp_peak};
                got[SF_GPU_TEMP_AVG]  = {8'h00, gpu_temp_avg};
                got[SF_GPU_TEMP_PEAK] = {8'h00, gpu_temp_peak};
                got[SF_CPU_LOAD_AVG]  = {9'h000, cpu_load_avg};
                got[SF_GPU_LOAD_AVG]  = {9'h000, gpu_load_avg};
                got[SF_RAM_AVG]       = {9'h000, ram_avg};
                got[SF_IDLE_MINUTES]  = idle_minutes;
                got[SF_CPU_IDLE_AVG]  = {8'h00, cpu_idle_temp_avg};
                got[SF_GPU_IDLE_AVG]  = {8'h00, gpu_idle_temp_avg};
                if (day_summaries.size() == 0)
                    note_failure($sformatf("unexpected summary for day %0h", closed_day));
                else
                begin
                    want = day_summaries.pop_front();
                    for (int i = 0; i < SUMMARY_FIELDS; i++)
                        if (got[i] !== want[i])
                            note_failure($sformatf("day %0h %s: expected %0h, got %0h",
                                want[SF_CLOSED_DAY], field_names[i], want[i], got[i]));
                end
                drain_stall = pick_gap();
            end
            if (drain_stall > 0)
            begin
                drain_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic queue_sample(input logic [15:0] day, input int ct, input int gt,
                                input int cl, input int gl, input int ram);
        sample_t s;
        s.day = day;
        s.cpu_t = ct[TW-1:0];
        s.gpu_t = gt[TW-1:0];
        s.cpu_l = cl[LOAD_WIDTH-1:0];
        s.gpu_l = gl[LOAD_WIDTH-1:0];
        s.ram = ram[LOAD_WIDTH-1:0];
        pending_samples.push_back(s);
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || day_summaries.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_idle_limit(input logic [LOAD_WIDTH-1:0] v);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        idle_limit = v;
        @(negedge clk);
    endtask

    function automatic int rand_temp();
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(0, 255);
        return $urandom_range(20, 95);
    endfunction

    function automatic int rand_load();
        int r;
        int hi;
        r = $urandom_range(0, 9);
        hi = (idle_limit >= 126) ? 127 : idle_limit + 1;
        if (r < 5)
            return $urandom_range(0, hi);
        if (r < 8)
            return $urandom_range(0, 100);
        return $urandom_range(0, 127);
    endfunction

    task automatic queue_random_days(input int target);
        int queued;
        int span;
        int r;
        logic [15:0] day;
        logic [15:0] prev_day;
        logic [15:0] swap;
        queued = 0;
        day = 16'($urandom);
        prev_day = day;
        while (queued < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                prev_day = day;
                day = day + 16'd1;
            end
            else if (r < 85)
            begin
                prev_day = day;
                day = 16'($urandom);
            end
            else
            begin
                swap = day;
                day = prev_day;
                prev_day = swap;
            end
            r = $urandom_range(0, 99);
            if (r < 80)
                span = $urandom_range(1, 8);
            else if (r < 95)
                span = $urandom_range(9, 25);
            else
                span = $urandom_range(40, 60);
            repeat (span)
                queue_sample(day, rand_temp(), rand_temp(), rand_load(), rand_load(),
                             rand_load());
            queued += span;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The idle limit is still at its reset value here.
        queue_sample(16'h0000, 127, -128, 0, 0, 0);
        queue_sample(16'h0000, -128, 127, 100, 100, 100);
        queue_sample(16'h0000, 127, 127, 127, 127, 127);
        queue_sample(16'hFFFF, -5, -128, 14, 14, 50);
        queue_sample(16'hFFFF, -1, -1, 15, 0, 1);
        queue_sample(16'h0001, 40, 60, 50, 50, 64);
        queue_sample(16'h0002, 0, 0, 0, 14, 0);
        queue_sample(16'h0002, 85, -40, 14, 15, 99);
        queue_sample(16'h5AA5, 33, 33, 1, 1, 33);
        wait_until_drained();

        write_idle_limit(7'd0);
        queue_sample(16'hA55A, 70, 71, 0, 0, 10);
        queue_sample(16'hA55A, -70, 20, 0, 127, 20);
        queue_sample(16'h0003, 12, -12, 0, 0, 0);
        wait_until_drained();

        write_idle_limit(7'd127);
        queue_sample(16'h0003, 10, 10, 126, 126, 5);
        queue_sample(16'h0003, 10, 10, 127, 0, 5);
        queue_sample(16'h0003, -9, 90, 100, 100, 77);
        queue_sample(16'h0004, 1, 2, 3, 4, 5);
        wait_until_drained();

        write_idle_limit(7'd101);
        queue_sample(16'h0005, 50, 50, 100, 100, 50);
        queue_sample(16'h0005, -100, 100, 101, 0, 0);
        queue_sample(16'h0006, 7, 7, 7, 7, 7);
        wait_until_drained();

        write_idle_limit(IDLE_LIMIT_RESET);
        queue_random_days(100);
        wait_until_drained();
        write_idle_limit(7'd100);
        queue_random_days(100);
        wait_until_drained();
        write_idle_limit(7'($urandom_range(1, 99)));
        steady_flow = 1'b1;
        queue_random_days(100);
        wait_until_drained();
        steady_flow = 1'b0;
        write_idle_limit(7'd0);
        queue_random_days(100);
        wait_until_drained();
        write_idle_limit(7'($urandom_range(0, 127)));
        queue_random_days(100);
        wait_until_drained();

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

/* daily_sensor_stats_accumulator.f */
src/dssa_pkg.sv
src/daily_sensor_stats_accumulator.sv
tb/daily_sensor_stats_accumulator_tb.sv
